@@ hw/rtl/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin task scheduler: table
// sizes, task state and operation codes, and the request, response and
// slot-pick structures.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int NUM_SIGNALS = 32;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int PEND_W      = 32;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2,
    TS_ZOMBIE  = 2'd3
  } tstate_t;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_TICK   = 3'd1,
    OP_BLOCK  = 3'd2,
    OP_WAKEUP = 3'd3,
    OP_EXIT   = 3'd4,
    OP_KILL   = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] slot;
    logic [4:0] signal_number;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        switched;
    logic [3:0]  from_slot;
    logic [3:0]  to_slot;
    logic [3:0]  created_slot;
    logic [31:0] target_pending;
  } rsp_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } pick_t;

endpackage

@@ hw/rtl/rrts_ram.sv @@
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rrts_pick.sv @@
// ----------------------------------------------------------------------------
// rrts_pick
// Rotating priority encoder: finds the first ready slot after the running
// slot, wrapping around, and never picks the running slot itself.
// ----------------------------------------------------------------------------
module rrts_pick (
  input  logic [rrts_pkg::MAX_SLOTS-1:0] ready_vec,
  input  logic [rrts_pkg::SLOT_W-1:0]    run,
  output rrts_pkg::pick_t                pick
);
  import rrts_pkg::*;

  logic [MAX_SLOTS-1:0] cand;
  logic [MAX_SLOTS-1:0] above;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      cand[i]  = ready_vec[i] && (i != int'(run));
      above[i] = cand[i] && (i > int'(run));
    end
    pick.found = |cand;
    pick.slot  = '0;
    // Lowest candidate overall covers the wrap; a candidate above the
    // running slot takes precedence.
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick.slot = SLOT_W'(i);
      end
    end
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (above[i]) begin
        pick.slot = SLOT_W'(i);
      end
    end
  end

endmodule

@@ hw/rtl/round_robin_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Flow: an accepted request executes in S_EXEC once its task state and
// pending-signal RAM reads are back; a switching tick adds S_WR2.
// The response is registered, and both states wait while it is stalled.
// Only one request is in flight: the next is accepted only in S_IDLE.
// Reset: synchronous; slot 0 is running, one task exists, no signals pending.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rrts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rrts_pkg::rsp_t rsp
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WR2  = 3'b100
  } fsm_t;

  fsm_t                 state, state_next;
  req_t                 req_q;
  pick_t                pick, pick_q;
  logic [SLOT_W-1:0]    addr_q, rd_addr;
  logic [CNT_W-1:0]     total, total_next;
  logic [SLOT_W-1:0]    run, run_next;
  logic [MAX_SLOTS-1:0] ready_vec;
  logic                 st0_vld, pd0_vld;

  logic                 st_we, pd_we;
  logic [SLOT_W-1:0]    st_waddr, pd_waddr;
  tstate_t              st_wdata;
  logic [1:0]           st_rdata;
  logic [PEND_W-1:0]    pd_wdata, pd_rdata;

  tstate_t              st_cur;
  logic [PEND_W-1:0]    pd_cur, pd_set;
  logic                 accept, out_free, tgt_ok, sig_ok, rsp_load;
  rsp_t                 rsp_next;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // Block, wakeup and kill address the requested slot; the rest the running one.
  always_comb begin
    if (state != S_IDLE) begin
      rd_addr = addr_q;
    end else if (req.op == OP_BLOCK || req.op == OP_WAKEUP || req.op == OP_KILL) begin
      rd_addr = SLOT_W'(req.slot);
    end else begin
      rd_addr = run;
    end
  end

  rrts_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  rrts_ram #(.WIDTH(PEND_W), .DEPTH(MAX_SLOTS)) u_pend_ram (
    .clk   (clk),
    .we    (pd_we),
    .waddr (pd_waddr),
    .wdata (pd_wdata),
    .raddr (rd_addr),
    .rdata (pd_rdata)
  );

  rrts_pick u_pick (
    .ready_vec (ready_vec),
    .run       (run),
    .pick      (pick)
  );

  // Slot 0 holds its reset contents until its entry is first written.
  assign st_cur = (addr_q == '0 && !st0_vld) ? TS_RUNNING : tstate_t'(st_rdata);
  assign pd_cur = (addr_q == '0 && !pd0_vld) ? '0 : pd_rdata;
  assign pd_set = pd_cur | (PEND_W'(1) << req_q.signal_number);
  assign tgt_ok = int'(req_q.slot) < int'(total);
  assign sig_ok = (req_q.signal_number != '0) &&
                  (int'(req_q.signal_number) < NUM_SIGNALS);

  always_comb begin
    state_next             = state;
    total_next             = total;
    run_next               = run;
    st_we                  = 1'b0;
    st_waddr               = addr_q;
    st_wdata               = TS_READY;
    pd_we                  = 1'b0;
    pd_waddr               = addr_q;
    pd_wdata               = pd_cur;
    rsp_load               = 1'b0;
    rsp_next               = '0;
    rsp_next.from_slot     = 4'(run);
    rsp_next.to_slot       = 4'(run);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          case (op_t'(req_q.op))
            OP_CREATE: begin
              if (int'(total) >= MAX_SLOTS) begin
                rsp_next.status = 1'b1;
              end else begin
                st_we                 = 1'b1;
                st_waddr              = SLOT_W'(total);
                st_wdata              = TS_READY;
                pd_we                 = 1'b1;
                pd_waddr              = SLOT_W'(total);
                pd_wdata              = '0;
                total_next            = total + CNT_W'(1);
                rsp_next.created_slot = 4'(total);
              end
            end
            OP_TICK: begin
              if (pick_q.found) begin
                // Demote the old task now if still running, promote the new one in S_WR2.
                rsp_load   = 1'b0;
                state_next = S_WR2;
                if (st_cur == TS_RUNNING) begin
                  st_we    = 1'b1;
                  st_wdata = TS_READY;
                end
              end
            end
            OP_BLOCK: begin
              if (!tgt_ok || st_cur == TS_ZOMBIE) begin
                rsp_next.status = 1'b1;
              end else begin
                st_we    = 1'b1;
                st_wdata = TS_BLOCKED;
              end
              if (tgt_ok) begin
                rsp_next.target_pending = pd_cur;
              end
            end
            OP_WAKEUP: begin
              if (!tgt_ok) begin
                rsp_next.status = 1'b1;
              end else begin
                if (st_cur == TS_BLOCKED) begin
                  st_we    = 1'b1;
                  st_wdata = TS_READY;
                end
                rsp_next.target_pending = pd_cur;
              end
            end
            OP_EXIT: begin
              st_we                   = 1'b1;
              st_wdata                = TS_ZOMBIE;
              rsp_next.target_pending = pd_cur;
            end
            OP_KILL: begin
              if (!sig_ok || !tgt_ok || st_cur == TS_ZOMBIE) begin
                rsp_next.status = 1'b1;
                if (tgt_ok) begin
                  rsp_next.target_pending = pd_cur;
                end
              end else begin
                pd_we    = 1'b1;
                pd_wdata = pd_set;
                if (st_cur == TS_BLOCKED) begin
                  st_we    = 1'b1;
                  st_wdata = TS_READY;
                end
                rsp_next.target_pending = pd_set;
              end
            end
            default: begin
              rsp_next.status = 1'b1;
            end
          endcase
        end
      end
      S_WR2: begin
        if (out_free) begin
          st_we             = 1'b1;
          st_waddr          = pick_q.slot;
          st_wdata          = TS_RUNNING;
          run_next          = pick_q.slot;
          rsp_load          = 1'b1;
          rsp_next.switched = 1'b1;
          rsp_next.to_slot  = 4'(pick_q.slot);
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= CNT_W'(1);
      run       <= '0;
      ready_vec <= '0;
      st0_vld   <= 1'b0;
      pd0_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      run   <= run_next;
      // The ready vector mirrors every state write for the tick search.
      if (st_we) begin
        ready_vec[st_waddr] <= (st_wdata == TS_READY);
        if (st_waddr == '0) begin
          st0_vld <= 1'b1;
        end
      end
      if (pd_we && pd_waddr == '0) begin
        pd0_vld <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req;
      addr_q <= rd_addr;
      pick_q <= pick;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_occupied: assert property (@(posedge clk) disable iff (rst)
    (ready_vec >> total) == '0)
    else $error("ready bit set on an empty slot");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total != '0 && int'(total) <= MAX_SLOTS)
    else $error("task count out of range");

  a_run_occupied: assert property (@(posedge clk) disable iff (rst)
    int'(run) < int'(total))
    else $error("running slot is not occupied");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("request accepted while another is in flight");

  a_switch_moves: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.switched || rsp.to_slot != rsp.from_slot))
    else $error("switch reported without a change of running slot");
`endif

endmodule
